// ----- rtl/core/contour_distance_accumulator_core_assert.svh -----
// Assertion macros for the contour distance accumulator
`ifndef CONTOUR_DISTANCE_ACCUMULATOR_CORE_ASSERT_SVH
`define CONTOUR_DISTANCE_ACCUMULATOR_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CDA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define CDA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/cda_pkg.sv -----
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types and constants of the contour distance accumulator.
// ----------------------------------------------------------------------------
package cda_pkg;
    localparam int MAX_CHAIN = 64;
    localparam int FRAC_BITS = 12;
    localparam int SLOTS     = MAX_CHAIN - 1;
    localparam int SLOT_W    = $clog2(SLOTS + 1);
    localparam int COORD_W   = 21;
    localparam int LEN_W     = 7;
    localparam int SEP_W     = 6;
    localparam int RMS_W     = 22;
    localparam int SUM_W     = 64;
    localparam int CNT_W     = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int D2_W      = SQ_W + 2;
    localparam logic [RMS_W-1:0] RMS_MAX = '1;

    localparam logic OP_POS    = 1'b0;
    localparam logic OP_REPORT = 1'b1;
    localparam logic [0:0] REG_CHAIN_LENGTH = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } pos_t;

    // control broadcast from the sequencer to the cell row
    typedef struct packed {
        logic load;   // new monomer on the row
        logic drop;   // chain closed: stored monomers no longer pair
        logic clear;  // zero all cells
        logic shift;  // pass bins toward the readout end
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } state_t;
endpackage

// ----- rtl/core/cda_if.sv -----
// ----------------------------------------------------------------------------
// cda_in_if / cda_out_if
// Valid/ready channels of the accumulator.
// ----------------------------------------------------------------------------
interface cda_in_if;
    import cda_pkg::*;
    logic valid;
    logic ready;
    logic op;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    modport source (output valid, op, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, op, pos_x, pos_y, pos_z, output ready);
endinterface

interface cda_out_if;
    import cda_pkg::*;
    logic valid;
    logic ready;
    logic [SEP_W-1:0] separation;
    logic [RMS_W-1:0] rms_distance;
    logic data_valid;
    logic last;
    modport source (output valid, separation, rms_distance, data_valid, last, input ready);
    modport sink (input valid, separation, rms_distance, data_valid, last, output ready);
endinterface

// ----- rtl/core/contour_distance_accumulator_core.sv -----
// Monomer items are taken back to back, one per cycle, while no report drains;
// ready stays high for them. A report gives L-1 results, each through a start
// state, the serial divide, the serial root, a done step and an output state
// that waits for the sink; then a clear state, after which ready returns.
// Reset: async active low clears bins, counters; chain_length back to 64.
// ----------------------------------------------------------------------------
// contour_distance_accumulator_core
// Row of SLOTS cells pairs each monomer with the stored chain; a sequencer
// drains the bins through a serial divide/root unit on a report.
// ----------------------------------------------------------------------------
module contour_distance_accumulator_core
    import cda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    cda_in_if.sink            in_ch,
    cda_out_if.source         out_ch
);
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] eff_len;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] chains_reg;
    logic [SEP_W-1:0] sep_reg;
    state_t state_reg, state_next;
    cell_ctrl_t ctrl;
    logic accept, closes;
    pos_t new_pos;
    logic dv_start, dv_done;
    logic [RMS_W-1:0] root;
    logic [RMS_W-1:0] rms_reg;
    logic [SUM_W-1:0] den;

    pos_t             chain_pos [SLOTS+1];
    logic             chain_vld [SLOTS+1];
    logic [SUM_W-1:0] chain_bin [SLOTS+1];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CHAIN_LENGTH) ? {25'd0, len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= LEN_W'(MAX_CHAIN);
        else if (psel && penable && pwrite && paddr[2] == REG_CHAIN_LENGTH)
            len_reg <= pwdata[LEN_W-1:0];
    end

    assign eff_len = (len_reg < LEN_W'(2)) ? LEN_W'(2)
                   : (len_reg > LEN_W'(MAX_CHAIN)) ? LEN_W'(MAX_CHAIN) : len_reg;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign new_pos = '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z};
    assign closes = (LEN_W'(pos_reg) + 1'b1) >= eff_len;

    // cell 0 takes the new monomer unless it closes the chain
    assign chain_pos[0] = new_pos;
    assign chain_vld[0] = !closes;
    assign chain_bin[SLOTS] = '0;

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            cda_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .new_pos(new_pos),
                .pos_in (chain_pos[k]),
                .vld_in (chain_vld[k]),
                .bin_in (chain_bin[k+1]),
                .pos_out(chain_pos[k+1]),
                .vld_out(chain_vld[k+1]),
                .bin_out(chain_bin[k])
            );
        end
    endgenerate

    // a closing monomer still pairs with the stored chain, then drops every
    // valid bit so the next chain starts empty; bins are kept
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && in_ch.op == OP_REPORT) state_next = ST_DIV;
            ST_DIV:  state_next = ST_SQRT;
            ST_SQRT: if (dv_done) state_next = ST_OUT;
            ST_OUT:
                if (out_ch.ready)
                    state_next = (LEN_W'(sep_reg) + 1'b1 == eff_len) ? ST_PAIR : ST_DIV;
            ST_PAIR: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        dv_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = accept && in_ch.op == OP_POS;
                ctrl.drop = accept && in_ch.op == OP_POS && closes;
            end
            ST_DIV:  dv_start = 1'b1;
            ST_OUT:  ctrl.shift = out_ch.ready;
            ST_PAIR: ctrl.clear = 1'b1;
            default: ctrl = '0;
        endcase
    end

    assign den = SUM_W'(chains_reg) * SUM_W'(eff_len - LEN_W'(sep_reg));

    cda_divsqrt u_divsqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .start(dv_start),
        .num  (chain_bin[0]),
        .den  (den),
        .done (dv_done),
        .root (root)
    );

    always_comb
    begin
        pos_next = pos_reg;
        if (ctrl.clear)
            pos_next = '0;
        else if (ctrl.load)
            pos_next = closes ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            chains_reg <= '0;
            sep_reg    <= SEP_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (ctrl.clear)
                chains_reg <= '0;
            else if (ctrl.load && closes && chains_reg != '1)
                chains_reg <= chains_reg + 1'b1;
            if (ctrl.clear)
                sep_reg <= SEP_W'(1);
            else if (ctrl.shift)
                sep_reg <= sep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_done)
            rms_reg <= (chains_reg == '0) ? '0 : root;
    end

    assign out_ch.valid        = (state_reg == ST_OUT);
    assign out_ch.separation   = sep_reg;
    assign out_ch.rms_distance = rms_reg;
    assign out_ch.data_valid   = (chains_reg != '0);
    assign out_ch.last         = (LEN_W'(sep_reg) + 1'b1 == eff_len);
endmodule

// ----- rtl/core/cda_cell.sv -----
// ----------------------------------------------------------------------------
// cda_cell
// One slot of the chain: holds an earlier monomer and one separation bin.
// ----------------------------------------------------------------------------
module cda_cell
    import cda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  pos_t             new_pos,
    input  pos_t             pos_in,
    input  logic             vld_in,
    input  logic [SUM_W-1:0] bin_in,
    output pos_t             pos_out,
    output logic             vld_out,
    output logic [SUM_W-1:0] bin_out
);
    pos_t             pos_reg;
    logic             vld_reg;
    logic [SUM_W-1:0] bin_reg, bin_next;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [D2_W-1:0] d2;
    logic [SUM_W:0]  sum;

    // cell k holds monomer pos-1-k, so its pair falls in bin k
    assign dx = DIFF_W'(new_pos.x) - DIFF_W'(pos_reg.x);
    assign dy = DIFF_W'(new_pos.y) - DIFF_W'(pos_reg.y);
    assign dz = DIFF_W'(new_pos.z) - DIFF_W'(pos_reg.z);
    assign d2 = D2_W'(unsigned'(SQ_W'(dx * dx))) + D2_W'(unsigned'(SQ_W'(dy * dy)))
              + D2_W'(unsigned'(SQ_W'(dz * dz)));
    assign sum = {1'b0, bin_reg} + (SUM_W + 1)'(d2);

    always_comb
    begin
        bin_next = bin_reg;
        if (ctrl.clear)
            bin_next = '0;
        else if (ctrl.shift)
            bin_next = bin_in;
        else if (ctrl.load && vld_reg)
            bin_next = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            bin_reg <= '0;
        end
        else
        begin
            bin_reg <= bin_next;
            if (ctrl.clear || ctrl.drop)
                vld_reg <= 1'b0;
            else if (ctrl.load)
                vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            pos_reg <= pos_in;
    end

    assign pos_out = pos_reg;
    assign vld_out = vld_reg;
    assign bin_out = bin_reg;
endmodule

// ----- rtl/core/cda_divsqrt.sv -----
// ----------------------------------------------------------------------------
// cda_divsqrt
// Bit-serial divide then bit-serial integer root, one bit per cycle.
// ----------------------------------------------------------------------------
module cda_divsqrt
    import cda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] num,
    input  logic [SUM_W-1:0] den,
    output logic             done,
    output logic [RMS_W-1:0] root
);
    localparam int CW = $clog2(SUM_W + 1);
    logic [SUM_W-1:0] q_reg, den_reg, res_reg;
    logic [SUM_W:0]   rem_reg;
    logic [SUM_W+1:0] srem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             dphase_reg, busy_reg;
    logic [SUM_W:0]   trial;
    logic [SUM_W+1:0] strial, scand;

    assign trial  = {rem_reg[SUM_W-1:0], q_reg[SUM_W-1]};
    assign strial = {srem_reg[SUM_W-1:0], q_reg[SUM_W-1:SUM_W-2]};
    assign scand  = {res_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done       <= 1'b0;
            dphase_reg <= 1'b0;
            cnt_reg    <= '0;
            q_reg      <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            srem_reg   <= '0;
            res_reg    <= '0;
        end
        else
        begin
            if (start)
            begin
                done       <= 1'b0;
                busy_reg   <= 1'b1;
                dphase_reg <= 1'b1;
                cnt_reg    <= CW'(SUM_W);
                q_reg      <= num;
                den_reg    <= den;
                rem_reg    <= '0;
            end
            else if (busy_reg && dphase_reg)
            begin
                done <= 1'b0;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    q_reg   <= {q_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[SUM_W-2:0], 1'b0};
                end
                if (cnt_reg == CW'(1))
                begin
                    dphase_reg <= 1'b0;
                    cnt_reg    <= CW'(SUM_W / 2);
                    srem_reg   <= '0;
                    res_reg    <= '0;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
            else if (busy_reg)
            begin
                q_reg <= {q_reg[SUM_W-3:0], 2'b00};
                if (strial >= scand)
                begin
                    srem_reg <= strial - scand;
                    res_reg  <= {res_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= strial;
                    res_reg  <= {res_reg[SUM_W-2:0], 1'b0};
                end
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= (cnt_reg != CW'(1));
                done     <= (cnt_reg == CW'(1));
            end
            else
                done <= 1'b0;
        end
    end

    assign root = (|res_reg[SUM_W-1:RMS_W]) ? RMS_MAX : res_reg[RMS_W-1:0];
endmodule

// ----- rtl/core/cda_checker.sv -----
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks on the accumulator.
// ----------------------------------------------------------------------------
`include "contour_distance_accumulator_core_assert.svh"
module cda_checker
    import cda_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SEP_W-1:0] separation,
    input logic             data_valid,
    input logic [RMS_W-1:0] rms_distance,
    input logic             last
);
    `CDA_ASSERT_IMP(a_no_overlap, clk, rst_n, in_valid && in_ready, !out_valid)
    `CDA_ASSERT_IMP(a_zero_invalid, clk, rst_n, out_valid && !data_valid, rms_distance == '0)
    `CDA_ASSERT_IMP(a_sep_nonzero, clk, rst_n, out_valid, separation != '0)
    `CDA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(separation))
    `CDA_ASSERT_NEXT(a_last_end, clk, rst_n, out_valid && out_ready && last, !out_valid)
endmodule

bind contour_distance_accumulator_core cda_checker u_cda_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .separation  (out_ch.separation),
    .data_valid  (out_ch.data_valid),
    .rms_distance(out_ch.rms_distance),
    .last        (out_ch.last)
);

// ----- sim/contour_distance_accumulator_core_tb.sv -----
// ----------------------------------------------------------------------------
// contour_distance_accumulator_core_tb
// Streams monomer chains and report items into the accumulator, predicts
// every per-separation result in the testbench and checks it field by field.
// ----------------------------------------------------------------------------
module contour_distance_accumulator_core_tb;
    import cda_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 250;   // covers one divide/root step and more

    typedef struct packed {
        logic [SEP_W-1:0] separation;
        logic [RMS_W-1:0] rms_distance;
        logic             data_valid;
        logic             last;
    } result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cda_in_if  in_ch();
    cda_out_if out_ch();

    contour_distance_accumulator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    // predictor state
    logic [LEN_W-1:0]        chain_len_reg;
    logic signed [COORD_W-1:0] chain_x [SLOTS];
    logic signed [COORD_W-1:0] chain_y [SLOTS];
    logic signed [COORD_W-1:0] chain_z [SLOTS];
    int unsigned             chain_index;
    logic [SUM_W-1:0]        bin_sum [SLOTS];
    logic [CNT_W-1:0]        chains_done;

    result_t pending_results[$];
    int      fail_count;
    bit      idle_en;
    int      sink_hold;
    int      cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned active_length();
        int unsigned l;
        l = chain_len_reg;
        if (l < 2) l = 2;
        if (l > MAX_CHAIN) l = MAX_CHAIN;
        return l;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void clear_chain_state();
        for (int i = 0; i < SLOTS; i++)
        begin
            chain_x[i] = '0;
            chain_y[i] = '0;
            chain_z[i] = '0;
            bin_sum[i] = '0;
        end
        chain_index = 0;
        chains_done = '0;
    endfunction

    // Expected results of one accepted item
    function automatic void predict_item(logic op, logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y,
                                         logic signed [COORD_W-1:0] z);
        int unsigned len;
        int unsigned pos;
        longint dx, dy, dz;
        logic [63:0] d2;
        logic [64:0] acc;
        logic [63:0] den;
        logic [63:0] rms;
        result_t r;
        len = active_length();
        if (op == OP_POS)
        begin
            pos = (chain_index > SLOTS) ? SLOTS : chain_index;
            for (int k = 0; k < pos; k++)
            begin
                dx  = longint'(x) - longint'(chain_x[k]);
                dy  = longint'(y) - longint'(chain_y[k]);
                dz  = longint'(z) - longint'(chain_z[k]);
                d2  = dx * dx + dy * dy + dz * dz;
                acc = {1'b0, bin_sum[pos-k-1]} + {1'b0, d2};
                bin_sum[pos-k-1] = acc[64] ? '1 : acc[63:0];
            end
            if (pos + 1 >= len)
            begin
                // chain closes, also when the length shrank mid chain
                chain_index = 0;
                if (chains_done != '1) chains_done = chains_done + 1;
            end
            else
            begin
                chain_x[pos] = x;
                chain_y[pos] = y;
                chain_z[pos] = z;
                chain_index  = pos + 1;
            end
        end
        else
        begin
            for (int unsigned s = 1; s < len; s++)
            begin
                rms = 0;
                if (chains_done != 0)
                begin
                    den = 64'(chains_done) * 64'(len - s);
                    rms = int_root(bin_sum[s-1] / den);
                    if (rms > 64'(RMS_MAX)) rms = 64'(RMS_MAX);
                end
                r.separation   = SEP_W'(s);
                r.rms_distance = rms[RMS_W-1:0];
                r.data_valid   = (chains_done != 0);
                r.last         = (s + 1 == len);
                pending_results.insert(pending_results.size(), r);
            end
            clear_chain_state();
        end
    endfunction

    // One item onto the input channel; valid stays high until a gap lowers it
    task automatic send_item(logic op, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.pos_x <= x;
        in_ch.pos_y <= y;
        in_ch.pos_z <= z;
        do @(posedge clk); while (!in_ch.ready);
        predict_item(op, x, y, z);
    endtask

    task automatic send_monomer(logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z);
        send_item(OP_POS, x, y, z);
    endtask

    // report item; position fields carry junk since they are ignored
    task automatic send_report();
        send_item(OP_REPORT, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // block idle: input dropped, every result in, then a settle time
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_chain_length(logic [LEN_W-1:0] value);
        wait_quiet();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(REG_CHAIN_LENGTH * 4);
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        chain_len_reg = value;
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            2, 3: return COORD_W'($urandom_range(0, 16383)) - COORD_W'(8192);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic send_chains(int n);
        for (int c = 0; c < n; c++)
            for (int m = 0; m < active_length(); m++)
                send_monomer(rand_coord(), rand_coord(), rand_coord());
    endtask

    // ---- tests ----

    // Report before any chain: zero results flagged invalid
    task automatic test_empty_report();
        write_chain_length(7'd4);
        send_report();
    endtask

    // Field extremes on the shortest chain
    task automatic test_extremes();
        logic signed [COORD_W-1:0] lo, hi;
        lo = {1'b1, {(COORD_W-1){1'b0}}};
        hi = {1'b0, {(COORD_W-1){1'b1}}};
        write_chain_length(7'd2);
        send_monomer(lo, lo, lo);
        send_monomer(hi, hi, hi);
        send_monomer(hi, lo, hi);
        send_monomer(lo, hi, lo);
        send_monomer('0, '0, '0);
        send_monomer('1, '1, '1);
        send_report();
    endtask

    // Lengths outside [2, 64] are clamped
    task automatic test_clamping();
        write_chain_length(7'd0);
        send_chains(2);
        send_report();
        write_chain_length(7'd1);
        send_chains(1);
        send_report();
        write_chain_length(7'd127);
        send_chains(1);
        send_report();
    endtask

    // Shrinking the length mid chain closes the chain on the next monomer
    task automatic test_mid_chain_change();
        write_chain_length(7'd8);
        repeat (5) send_monomer(rand_coord(), rand_coord(), rand_coord());
        write_chain_length(7'd3);
        send_monomer(rand_coord(), rand_coord(), rand_coord());
        send_chains(1);
        send_report();
        // stale long bins must be gone after that report
        write_chain_length(7'd8);
        send_chains(1);
        send_report();
    endtask

    // Random phases: well-formed chains, partial chains, stray reports
    task automatic test_random();
        int sent;
        int plen;
        int tail;
        sent = 0;
        while (sent < 160)
        begin
            case ($urandom_range(0, 9))
                0: plen = 64;
                1, 2: plen = $urandom_range(9, 20);
                default: plen = $urandom_range(2, 8);
            endcase
            if (sent > 110) idle_en = 1'b0;
            write_chain_length(LEN_W'(plen));
            for (int c = $urandom_range(1, (plen > 16) ? 2 : 5); c > 0; c--)
            begin
                send_chains(1);
                sent += plen;
                if ($urandom_range(0, 5) == 0)
                begin
                    // broken tail left in the chain
                    tail = $urandom_range(1, plen - 1);
                    repeat (tail)
                        send_monomer(rand_coord(), rand_coord(), rand_coord());
                    sent += tail;
                end
            end
            send_report();
            sent++;
            if ($urandom_range(0, 7) == 0)
            begin
                send_report();
                sent++;
            end
        end
    endtask

    // ---- result checking and sink stalls ----
    always @(posedge clk)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_hold = 0;
        end
        else
        begin
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                sink_hold = $urandom_range(1, 15) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result separation=%0d", out_ch.separation);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (out_ch.separation !== exp_r.separation)
                    begin
                        $error("separation expected %0d actual %0d",
                               exp_r.separation, out_ch.separation);
                        fail_count++;
                    end
                    if (out_ch.rms_distance !== exp_r.rms_distance)
                    begin
                        $error("rms_distance expected %0d actual %0d",
                               exp_r.rms_distance, out_ch.rms_distance);
                        fail_count++;
                    end
                    if (out_ch.data_valid !== exp_r.data_valid)
                    begin
                        $error("data_valid expected %0d actual %0d",
                               exp_r.data_valid, out_ch.data_valid);
                        fail_count++;
                    end
                    if (out_ch.last !== exp_r.last)
                    begin
                        $error("last expected %0d actual %0d",
                               exp_r.last, out_ch.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        fail_count    = 0;
        cycles        = 0;
        idle_en       = 1'b1;
        chain_len_reg = 7'd64;
        clear_chain_state();
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_POS;
        in_ch.pos_x <= '0;
        in_ch.pos_y <= '0;
        in_ch.pos_z <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_report();
        test_extremes();
        test_clamping();
        test_mid_chain_change();
        test_random();

        wait_quiet();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cda_pkg.sv
rtl/core/cda_if.sv
rtl/core/cda_cell.sv
rtl/core/cda_divsqrt.sv
rtl/core/contour_distance_accumulator_core.sv
rtl/core/cda_checker.sv
sim/contour_distance_accumulator_core_tb.sv
